>>> rtl/core/linear_congruence_solver_defines.svh
// ----------------------------------------------------------------------------
// Linear congruence solver assertion macros
// Assertion helpers shared by the solver RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH
`define LINEAR_CONGRUENCE_SOLVER_DEFINES_SVH
`ifndef ASSERT_OFF
`define LCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/lcs_pkg.sv
// ----------------------------------------------------------------------------
// Linear congruence solver package
// Sequencer state encoding, divider status struct and reduction count.
// ----------------------------------------------------------------------------
`default_nettype none
package lcs_pkg;
    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_RED    = 12'b000000000010,
        ST_DIFF   = 12'b000000000100,
        ST_GCD    = 12'b000000001000,
        ST_CHK    = 12'b000000010000,
        ST_T      = 12'b000000100000,
        ST_NORM   = 12'b000001000000,
        ST_INV    = 12'b000010000000,
        ST_MUL    = 12'b000100000000,
        ST_FIN    = 12'b001000000000,
        ST_OUT    = 12'b010000000000,
        ST_WAIT   = 12'b100000000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_ctl_t;

    localparam int unsigned RED_OPS = 4;
endpackage
`default_nettype wire

>>> rtl/core/lcs_divider.sv
// ----------------------------------------------------------------------------
// Linear congruence solver serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_congruence_solver_defines.svh"
module lcs_divider #(
    parameter int unsigned W = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [W-1:0]    dividend,
    input  wire logic [W-1:0]    divisor,
    output logic                 busy,
    output logic                 done,
    output logic [W-1:0]         quotient,
    output logic [W-1:0]         remainder
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `LCS_ASSERT_IMP(a_done_not_busy, aclk, aresetn, done_reg, !busy_reg)
    `LCS_ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg)
    `LCS_ASSERT_IMP(a_cnt_busy, aclk, aresetn, busy_reg, cnt_reg != '0)
endmodule
`default_nettype wire

>>> rtl/core/linear_congruence_solver.sv
// ----------------------------------------------------------------------------
// Linear congruence solver
// Solves (step_first - step_second) * x = start_second - start_first mod
// ring_length with a serial divider and bit-serial modular multiplication.
// ----------------------------------------------------------------------------
// Steps: one division per gcd step, one division and one serial multiply per
//   inverse step, up to 2*W+2 steps each, plus four reductions.
// Throughput: one transaction at a time, through the shared divider and the
//   multiplier, each of which handles one bit per cycle.
// Reset: synchronous active-low aresetn returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_congruence_solver_defines.svh"
module linear_congruence_solver #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // start_first, start_second, step_first, step_second, ring_length
    input  wire logic [5*(WIDTH-1)+((8-((5*(WIDTH-1))%8))%8)-1:0] s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // jump_count
    output logic [WIDTH-1+((8-((WIDTH-1)%8))%8)-1:0] m_tdata,
    // no_solution
    output logic                   m_tuser
);
    localparam int unsigned FW = WIDTH - 1;
    localparam int unsigned W  = WIDTH;
    localparam int unsigned OW = WIDTH - 1 + ((8 - ((WIDTH - 1) % 8)) % 8);
    localparam int unsigned LB = 2 * WIDTH + 2;
    localparam int unsigned LW = $clog2(LB + 1);
    localparam int unsigned MW = $clog2(W + 1);

    lcs_pkg::state_t st_reg, st_next;

    logic [W-1:0] len_reg, len_next;
    logic [W-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [W-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [W-1:0] diff_reg, diff_next, offs_reg, offs_next;
    logic [W-1:0] u_reg, u_next, v_reg, v_next;
    logic [W-1:0] t_reg, t_next;
    logic [W-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [W-1:0] acc_reg, acc_next, p_reg, p_next, q_reg, q_next;
    logic [W-1:0] res_reg, res_next;
    logic         nos_reg, nos_next;
    logic [LW-1:0] it_reg, it_next;
    logic [2:0]   sub_reg, sub_next;
    logic [MW-1:0] mc_reg, mc_next;
    logic         dwait_reg, dwait_next;
    logic         mfin_reg, mfin_next;

    logic         dv_start;
    logic [W-1:0] dv_a, dv_b, dv_q, dv_r;
    lcs_pkg::div_ctl_t dctl;
    logic [W:0]   add_sum, dbl_sum;
    logic [W-1:0] add_mod, dbl_mod;

    lcs_divider #(.W(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(dv_a), .divisor(dv_b),
        .busy(dctl.busy), .done(dctl.done),
        .quotient(dv_q), .remainder(dv_r)
    );

    // Modular add/double for the bit-serial multiplier (operands at most t).
    always_comb begin
        add_sum = {1'b0, acc_reg} + {1'b0, p_reg};
        add_mod = (add_sum >= {1'b0, t_reg}) ? W'(add_sum - {1'b0, t_reg})
                                             : add_sum[W-1:0];
        dbl_sum = {p_reg, 1'b0};
        dbl_mod = (dbl_sum >= {1'b0, t_reg}) ? W'(dbl_sum - {1'b0, t_reg})
                                             : dbl_sum[W-1:0];
    end

    always_comb begin
        st_next = st_reg;
        len_next = len_reg; sa_next = sa_reg; sb_next = sb_reg;
        ma_next = ma_reg; mb_next = mb_reg;
        diff_next = diff_reg; offs_next = offs_reg;
        u_next = u_reg; v_next = v_reg; t_next = t_reg;
        s0_next = s0_reg; s1_next = s1_reg;
        acc_next = acc_reg; p_next = p_reg; q_next = q_reg;
        res_next = res_reg; nos_next = nos_reg;
        it_next = it_reg; sub_next = sub_reg; mc_next = mc_reg;
        dwait_next = dwait_reg; mfin_next = mfin_reg;
        dv_start = 1'b0; dv_a = '0; dv_b = '0;
        case (st_reg)
            lcs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    sa_next  = W'(s_tdata[FW-1:0]);
                    sb_next  = W'(s_tdata[2*FW-1:FW]);
                    ma_next  = W'(s_tdata[3*FW-1:2*FW]);
                    mb_next  = W'(s_tdata[4*FW-1:3*FW]);
                    len_next = W'(s_tdata[5*FW-1:4*FW]);
                    sub_next = '0;
                    dwait_next = 1'b0;
                    if (s_tdata[5*FW-1:4*FW] == '0) begin
                        nos_next = 1'b1; res_next = '0;
                        st_next = lcs_pkg::ST_OUT;
                    end else begin
                        st_next = lcs_pkg::ST_RED;
                    end
                end
            end
            lcs_pkg::ST_RED: begin
                if (!dwait_reg) begin
                    dv_start = 1'b1; dv_b = len_reg;
                    case (sub_reg)
                        3'd0: dv_a = ma_reg;
                        3'd1: dv_a = mb_reg;
                        3'd2: dv_a = sa_reg;
                        default: dv_a = sb_reg;
                    endcase
                    dwait_next = 1'b1;
                end else if (dctl.done) begin
                    dwait_next = 1'b0;
                    case (sub_reg)
                        3'd0: ma_next = dv_r;
                        3'd1: mb_next = dv_r;
                        3'd2: sa_next = dv_r;
                        default: sb_next = dv_r;
                    endcase
                    if (sub_reg == 3'(lcs_pkg::RED_OPS - 1)) begin
                        st_next = lcs_pkg::ST_DIFF;
                    end
                    sub_next = sub_reg + 1'b1;
                end
            end
            lcs_pkg::ST_DIFF: begin
                diff_next = (ma_reg >= mb_reg) ? ma_reg - mb_reg : ma_reg + (len_reg - mb_reg);
                offs_next = (sb_reg >= sa_reg) ? sb_reg - sa_reg : sb_reg + (len_reg - sa_reg);
                u_next = len_reg;
                v_next = (ma_reg >= mb_reg) ? ma_reg - mb_reg : ma_reg + (len_reg - mb_reg);
                it_next = '0;
                st_next = lcs_pkg::ST_GCD;
            end
            lcs_pkg::ST_GCD: begin
                if (!dwait_reg) begin
                    if (v_reg == '0 || it_reg == LW'(LB)) begin
                        dv_start = 1'b1; dv_a = offs_reg; dv_b = u_reg;
                        dwait_next = 1'b1;
                        st_next = lcs_pkg::ST_CHK;
                    end else begin
                        dv_start = 1'b1; dv_a = u_reg; dv_b = v_reg;
                        dwait_next = 1'b1;
                    end
                end else if (dctl.done) begin
                    dwait_next = 1'b0;
                    u_next = v_reg; v_next = dv_r;
                    it_next = it_reg + 1'b1;
                end
            end
            lcs_pkg::ST_CHK: begin
                // u holds g; the divider ran offs / g.
                if (dctl.done) begin
                    dwait_next = 1'b0;
                    if (dv_r != '0) begin
                        nos_next = 1'b1; res_next = '0;
                        st_next = lcs_pkg::ST_OUT;
                    end else begin
                        offs_next = dv_q;
                        dv_start = 1'b1; dv_a = len_reg; dv_b = u_reg;
                        dwait_next = 1'b1;
                        st_next = lcs_pkg::ST_T;
                    end
                end
            end
            lcs_pkg::ST_T: begin
                if (dwait_reg && dctl.done) begin
                    dwait_next = 1'b0;
                    t_next = dv_q;
                    nos_next = 1'b0;
                    if (dv_q <= W'(1)) begin
                        res_next = '0;
                        st_next = lcs_pkg::ST_OUT;
                    end else begin
                        dv_start = 1'b1; dv_a = diff_reg; dv_b = u_reg;
                        dwait_next = 1'b1;
                        st_next = lcs_pkg::ST_NORM;
                    end
                end
            end
            lcs_pkg::ST_NORM: begin
                // diff/g < t and offs/g < t already, so no extra reduction.
                if (dctl.done) begin
                    dwait_next = 1'b0;
                    u_next = t_reg; v_next = dv_q;
                    s0_next = '0; s1_next = W'(1);
                    it_next = '0; sub_next = '0;
                    st_next = lcs_pkg::ST_INV;
                end
            end
            lcs_pkg::ST_INV: begin
                case (sub_reg)
                    3'd0: begin
                        if (v_reg == '0 || it_reg == LW'(LB)) begin
                            acc_next = '0; p_next = s0_reg; q_next = offs_reg;
                            mc_next = MW'(W); mfin_next = 1'b1;
                            st_next = lcs_pkg::ST_MUL;
                        end else begin
                            dv_start = 1'b1; dv_a = u_reg; dv_b = v_reg;
                            sub_next = 3'd1;
                        end
                    end
                    3'd1: begin
                        if (dctl.done) begin
                            // q = r0 / r1 is at most t; a multiplicand equal
                            // to t adds nothing modulo t, as q % t would.
                            acc_next = '0; p_next = dv_q; q_next = s1_reg;
                            mc_next = MW'(W); mfin_next = 1'b0;
                            st_next = lcs_pkg::ST_MUL;
                            sub_next = 3'd2;
                        end
                    end
                    default: begin
                        s0_next = s1_reg;
                        s1_next = (s0_reg >= acc_reg) ? s0_reg - acc_reg
                                                      : s0_reg + (t_reg - acc_reg);
                        u_next = v_reg; v_next = dv_r;
                        it_next = it_reg + 1'b1;
                        sub_next = 3'd0;
                    end
                endcase
            end
            lcs_pkg::ST_MUL: begin
                if (q_reg[0]) acc_next = add_mod;
                p_next = dbl_mod;
                q_next = q_reg >> 1;
                mc_next = mc_reg - 1'b1;
                if (mc_reg == MW'(1)) begin
                    st_next = mfin_reg ? lcs_pkg::ST_FIN : lcs_pkg::ST_INV;
                end
            end
            lcs_pkg::ST_FIN: begin
                res_next = acc_reg;
                nos_next = 1'b0;
                st_next = lcs_pkg::ST_OUT;
            end
            lcs_pkg::ST_OUT: begin
                st_next = lcs_pkg::ST_WAIT;
            end
            lcs_pkg::ST_WAIT: begin
                if (m_tready) st_next = lcs_pkg::ST_IDLE;
            end
            default: st_next = lcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= lcs_pkg::ST_IDLE;
            dwait_reg <= 1'b0;
            sub_reg   <= '0;
            it_reg    <= '0;
            mc_reg    <= '0;
            mfin_reg  <= 1'b0;
        end else begin
            st_reg    <= st_next;
            dwait_reg <= dwait_next;
            sub_reg   <= sub_next;
            it_reg    <= it_next;
            mc_reg    <= mc_next;
            mfin_reg  <= mfin_next;
        end
        len_reg <= len_next; sa_reg <= sa_next; sb_reg <= sb_next;
        ma_reg <= ma_next; mb_reg <= mb_next;
        diff_reg <= diff_next; offs_reg <= offs_next;
        u_reg <= u_next; v_reg <= v_next; t_reg <= t_next;
        s0_reg <= s0_next; s1_reg <= s1_next;
        acc_reg <= acc_next; p_reg <= p_next; q_reg <= q_next;
        res_reg <= res_next; nos_reg <= nos_next;
    end

    assign s_tready = (st_reg == lcs_pkg::ST_IDLE);
    assign m_tvalid = (st_reg == lcs_pkg::ST_WAIT);
    assign m_tdata  = OW'(res_reg[FW-1:0]);
    assign m_tuser  = nos_reg;

    `LCS_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    `LCS_ASSERT_IMP(a_nos_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `LCS_ASSERT_IMP(a_mul_idle_div, aclk, aresetn, st_reg == lcs_pkg::ST_MUL, !dctl.busy)
    `LCS_ASSERT_NEXT(a_out_wait, aclk, aresetn, st_reg == lcs_pkg::ST_OUT, m_tvalid)
endmodule
`default_nettype wire

>>> tb/linear_congruence_solver_tb.sv
// ----------------------------------------------------------------------------
// Linear congruence solver testbench
// Drives ring and walker transactions through the input stream and compares
// every result transaction with a behavioral solver kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module linear_congruence_solver_tb;
    localparam int unsigned WIDTH = 32;
    localparam int unsigned FW = WIDTH - 1;
    localparam int unsigned SW = 5*FW + ((8 - ((5*FW) % 8)) % 8);
    localparam int unsigned MW = FW + ((8 - (FW % 8)) % 8);
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam logic [30:0] FMAX = 31'h7FFFFFFF;

    typedef struct packed {
        logic [30:0] ring_length;
        logic [30:0] step_second;
        logic [30:0] step_first;
        logic [30:0] start_second;
        logic [30:0] start_first;
    } walk_t;

    typedef struct packed {
        logic        no_solution;
        logic [30:0] jump_count;
    } meet_t;

    typedef struct {
        walk_t w;
        logic  known;
        meet_t m;
    } row_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [SW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [MW-1:0] m_tdata;
    logic          m_tuser;

    meet_t meet_queue[$];
    int    errors;
    int    idle_cycles;
    int    rx_count;
    bit    sending_done;
    bit    quiet_sender;
    bit    quiet_receiver;
    bit    hold_off;
    row_t  rows[$];

    linear_congruence_solver #(.WIDTH(WIDTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic longint unsigned mulmod(longint unsigned p, longint unsigned q,
                                               longint unsigned m);
        longint unsigned acc;
        acc = 0;
        while (q != 0) begin
            if (q[0]) acc = (acc + p) % m;
            q = q >> 1;
            p = (p + p) % m;
        end
        return acc;
    endfunction

    function automatic meet_t solve_meeting(walk_t w);
        longint unsigned len, sa, sb, ma, mb, diff, offs, g, u, v, r, t;
        longint unsigned r0, r1, s0, s1, q, s2, prod;
        meet_t res;
        res = '{no_solution: 1'b1, jump_count: '0};
        len = w.ring_length;
        if (len == 0) return res;
        sa = w.start_first % len;
        sb = w.start_second % len;
        ma = w.step_first % len;
        mb = w.step_second % len;
        diff = (ma + len - mb) % len;
        offs = (sb + len - sa) % len;
        u = len;
        v = diff;
        while (v != 0) begin
            r = u % v;
            u = v;
            v = r;
        end
        g = u;
        if (offs % g != 0) return res;
        res.no_solution = 1'b0;
        t = len / g;
        if (t > 1) begin
            r0 = t;
            r1 = (diff / g) % t;
            s0 = 0;
            s1 = 1;
            while (r1 != 0) begin
                q = r0 / r1;
                s2 = r0 - q * r1;
                r0 = r1;
                r1 = s2;
                prod = mulmod(q % t, s1, t);
                s2 = (s0 + t - prod) % t;
                s0 = s1;
                s1 = s2;
            end
            res.jump_count = 31'(mulmod(s0, (offs / g) % t, t));
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, meet_t got, meet_t want);
        $display("mismatch %s: got no_solution=%0d jump_count=%0d, want %0d/%0d",
                 what, got.no_solution, got.jump_count, want.no_solution, want.jump_count);
        errors++;
    endtask

    function automatic logic [30:0] rand_field(int unsigned lo);
        logic [30:0] f;
        case ($urandom_range(3))
            0: f = 31'($urandom_range(20));
            1: f = 31'($urandom_range(1000));
            2: f = FMAX - 31'($urandom_range(5));
            default: f = 31'($urandom());
        endcase
        if (f < lo) f = 31'(lo);
        return f;
    endfunction

    function automatic walk_t rand_walk();
        walk_t w;
        w.ring_length = rand_field(1);
        w.start_first = rand_field(0);
        w.start_second = rand_field(0);
        w.step_first = rand_field(1);
        w.step_second = ($urandom_range(9) == 0) ? w.step_first : rand_field(1);
        if ($urandom_range(3) == 0) w.ring_length = 31'($urandom_range(1, 64));
        return w;
    endfunction

    task automatic add_row(logic [30:0] sa, logic [30:0] sb, logic [30:0] ma,
                           logic [30:0] mb, logic [30:0] len, logic known,
                           logic ns, logic [30:0] jc);
        row_t r;
        r.w = '{ring_length: len, step_second: mb, step_first: ma,
                start_second: sb, start_first: sa};
        r.known = known;
        r.m = '{no_solution: ns, jump_count: jc};
        rows.push_back(r);
    endtask

    task automatic send_walk(walk_t w, meet_t want);
        while (!quiet_sender && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= SW'(w);
        meet_queue.push_back(want);
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        meet_t want;
        errors = 0;
        sending_done = 0;
        quiet_sender = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(0, 0, 1, 1, 1, 1, 0, 0);
        add_row(0, 5, 3, 3, 7, 1, 1, 0);
        add_row(4, 4, 3, 3, 7, 1, 0, 0);
        add_row(11, 4, 10, 3, 7, 1, 0, 0);
        add_row(0, 1, 2, 0, 4, 1, 1, 0);
        add_row(0, 1, 3, 2, 7, 1, 0, 1);
        add_row(0, 2, 2, 0, 4, 1, 0, 1);
        add_row(0, 6, 1, 2, 7, 1, 0, 1);
        add_row(FMAX, 0, FMAX, 1, FMAX, 0, 0, 0);
        add_row(0, FMAX, 1, FMAX, FMAX, 0, 0, 0);
        add_row(FMAX, FMAX, FMAX, FMAX, FMAX, 1, 0, 0);
        add_row(1, FMAX - 1, FMAX - 1, 1, FMAX - 2, 0, 0, 0);
        add_row(12345, 0, 6, 2, 1000000, 0, 0, 0);
        add_row(0, 1, 2, 1, FMAX - 1, 0, 0, 0);
        add_row(7, 3, 5, 1, 9973, 0, 0, 0);
        add_row(FMAX, FMAX, 1, 1, 2, 1, 0, 0);
        add_row(0, 1, 5, 1, 2, 1, 1, 0);
        foreach (rows[i]) begin
            want = solve_meeting(rows[i].w);
            if (rows[i].known && want !== rows[i].m)
                report_mismatch("table entry", want, rows[i].m);
            send_walk(rows[i].w, want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            walk_t w;
            quiet_sender = (i >= 100 && i < 160);
            w = rand_walk();
            send_walk(w, solve_meeting(w));
        end
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    initial begin
        m_tready = 1'b0;
        quiet_receiver = 0;
        hold_off = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (rx_count >= 30 && meet_queue.size() >= 2 && !hold_off) begin
                hold_off = 1;
                m_tready <= 1'b0;
                repeat (30000) @(posedge aclk);
            end
            quiet_receiver = (rx_count >= 200 && rx_count < 260);
            m_tready <= quiet_receiver || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge aclk) begin
        meet_t got;
        if (!aresetn) begin
            rx_count = 0;
        end else if (m_tvalid && m_tready) begin
            got = '{no_solution: m_tuser, jump_count: m_tdata[30:0]};
            rx_count++;
            if (meet_queue.size() == 0) begin
                report_mismatch("unexpected transaction", got, got);
            end else begin
                if (got.no_solution !== meet_queue[0].no_solution ||
                    got.jump_count !== meet_queue[0].jump_count)
                    report_mismatch("result", got, meet_queue[0]);
                void'(meet_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (aresetn === 1'b1);
        while (!(sending_done && meet_queue.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("linear_congruence_solver_tb: FAIL");
        end else begin
            repeat (200) @(posedge aclk);
            if (errors == 0)
                $display("linear_congruence_solver_tb: PASS");
            else
                $display("linear_congruence_solver_tb: FAIL");
        end
        $finish;
    end
endmodule
